// ===== sv/act_sel_pkg.sv =====
// Package for the activity selection unit: sizes, entry type, cell ops, FSM states.
// No dependencies.
package act_sel_pkg;

  localparam int MAX_ACTIVITIES = 64;
  localparam int ID_W           = 15;
  localparam int TIME_W         = 15;
  localparam int CNT_W          = 7;
  localparam int STEP_W         = $clog2(MAX_ACTIVITIES);

  typedef struct packed {
    logic              valid;
    logic              mark;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_FROM_PREV,
    CELL_FROM_NEXT
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SELECT,
    ST_EMIT
  } state_t;

endpackage

// ===== sv/act_sel_cell.sv =====
// One cell of the sorting chain: holds one activity entry.
// Inserts by start time (descending, stable) or shifts to/from its neighbors.
// Depends on act_sel_pkg.
module act_sel_cell (
  input  logic                clk,
  input  logic                rst,
  input  act_sel_pkg::cell_op_t op,
  input  act_sel_pkg::entry_t ins,
  input  act_sel_pkg::entry_t prev,
  input  logic                prev_keep,
  input  act_sel_pkg::entry_t next,
  output act_sel_pkg::entry_t ent,
  output logic                keep
);

  act_sel_pkg::entry_t ent_next;

  assign keep = ent.valid && (ent.start_time >= ins.start_time);

  always_comb begin
    unique case (op)
      act_sel_pkg::CELL_HOLD: ent_next = ent;
      act_sel_pkg::CELL_INSERT: begin
        if (!prev_keep) begin
          ent_next = prev;
        end else if (!keep) begin
          ent_next = ins;
        end else begin
          ent_next = ent;
        end
      end
      act_sel_pkg::CELL_FROM_PREV: ent_next = prev;
      act_sel_pkg::CELL_FROM_NEXT: ent_next = next;
      default: ent_next = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
      ent.mark  <= 1'b0;
    end else begin
      ent <= ent_next;
    end
  end

endmodule

// ===== sv/act_sel_chain.sv =====
// Row of act_sel_cell instances; cell 0 holds the latest start time.
// Exposes head and tail entries; wrap feeds the tail on a left shift.
// Depends on act_sel_pkg and act_sel_cell.
module act_sel_chain (
  input  logic                  clk,
  input  logic                  rst,
  input  act_sel_pkg::cell_op_t op,
  input  act_sel_pkg::entry_t   ins,
  input  act_sel_pkg::entry_t   wrap,
  output act_sel_pkg::entry_t   head,
  output act_sel_pkg::entry_t   tail
);

  act_sel_pkg::entry_t ent  [act_sel_pkg::MAX_ACTIVITIES];
  logic                keep [act_sel_pkg::MAX_ACTIVITIES];

  for (genvar i = 0; i < act_sel_pkg::MAX_ACTIVITIES; i++) begin : g_cell
    act_sel_pkg::entry_t prev_e;
    act_sel_pkg::entry_t next_e;
    logic                prev_k;

    if (i == 0) begin : g_first
      assign prev_e = '0;
      assign prev_k = 1'b1;
    end else begin : g_mid
      assign prev_e = ent[i-1];
      assign prev_k = keep[i-1];
    end

    if (i == act_sel_pkg::MAX_ACTIVITIES - 1) begin : g_last
      assign next_e = wrap;
    end else begin : g_inner
      assign next_e = ent[i+1];
    end

    act_sel_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .op        (op),
      .ins       (ins),
      .prev      (prev_e),
      .prev_keep (prev_k),
      .next      (next_e),
      .ent       (ent[i]),
      .keep      (keep[i])
    );
  end

  assign head = ent[0];
  assign tail = ent[act_sel_pkg::MAX_ACTIVITIES-1];

endmodule

// ===== sv/activity_selection_sorted_unit.sv =====
// Greedy activity selection: activities load one per cycle into a sorted chain of
// cells (latest start first, ties in load order). The transfer marked last closes
// the set; the chain then rotates once through the selector and shifts out toward
// the output register, pausing while the output is stalled. in_ready is low during
// selection and emission. Items past capacity are dropped.
// Depends on act_sel_pkg and act_sel_chain.
module activity_selection_sorted_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [14:0] activity_id,
  input  logic [14:0] start_time,
  input  logic [14:0] end_time,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] chosen_id,
  output logic [6:0]  chosen_count,
  output logic        final_result
);

  act_sel_pkg::state_t   state, state_next;
  act_sel_pkg::cell_op_t op;
  act_sel_pkg::entry_t   ins, wrap, head, tail;

  logic [act_sel_pkg::CNT_W-1:0]  loaded, loaded_next;
  logic [act_sel_pkg::CNT_W-1:0]  cnt, cnt_next;
  logic [act_sel_pkg::CNT_W-1:0]  emitted, emitted_next;
  logic [act_sel_pkg::STEP_W-1:0] step, step_next;
  logic [act_sel_pkg::TIME_W-1:0] taken_start, taken_start_next;
  logic                           have_taken, have_taken_next;
  logic                           take;
  logic                           out_valid_next;
  logic [act_sel_pkg::ID_W-1:0]   out_id_next;
  logic [act_sel_pkg::CNT_W-1:0]  out_cnt_next;
  logic                           out_final_next;

  assign ins.valid      = 1'b1;
  assign ins.mark       = 1'b0;
  assign ins.id         = activity_id;
  assign ins.start_time = start_time;
  assign ins.end_time   = end_time;

  assign take = head.valid && (!have_taken || (head.end_time <= taken_start));

  always_comb begin
    wrap      = head;
    wrap.mark = head.mark | take;
  end

  act_sel_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .op   (op),
    .ins  (ins),
    .wrap (wrap),
    .head (head),
    .tail (tail)
  );

  always_comb begin
    state_next       = state;
    op               = act_sel_pkg::CELL_HOLD;
    in_ready         = 1'b0;
    loaded_next      = loaded;
    cnt_next         = cnt;
    emitted_next     = emitted;
    step_next        = step;
    taken_start_next = taken_start;
    have_taken_next  = have_taken;
    out_valid_next   = out_valid && !out_ready;
    out_id_next      = chosen_id;
    out_cnt_next     = chosen_count;
    out_final_next   = final_result;

    unique case (state)
      act_sel_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (loaded < act_sel_pkg::CNT_W'(act_sel_pkg::MAX_ACTIVITIES)) begin
            op          = act_sel_pkg::CELL_INSERT;
            loaded_next = loaded + act_sel_pkg::CNT_W'(1);
          end
          if (last) begin
            state_next      = act_sel_pkg::ST_SELECT;
            step_next       = '0;
            cnt_next        = '0;
            have_taken_next = 1'b0;
          end
        end
      end

      act_sel_pkg::ST_SELECT: begin
        op = act_sel_pkg::CELL_FROM_NEXT;
        if (take) begin
          taken_start_next = head.start_time;
          have_taken_next  = 1'b1;
          cnt_next         = cnt + act_sel_pkg::CNT_W'(1);
        end
        step_next = step + act_sel_pkg::STEP_W'(1);
        if (step == act_sel_pkg::STEP_W'(act_sel_pkg::MAX_ACTIVITIES - 1)) begin
          state_next   = act_sel_pkg::ST_EMIT;
          step_next    = '0;
          emitted_next = '0;
        end
      end

      act_sel_pkg::ST_EMIT: begin
        if (!out_valid || out_ready) begin
          op = act_sel_pkg::CELL_FROM_PREV;
          if (tail.valid && tail.mark) begin
            out_valid_next = 1'b1;
            out_id_next    = tail.id;
            out_cnt_next   = cnt;
            out_final_next = (emitted + act_sel_pkg::CNT_W'(1)) == cnt;
            emitted_next   = emitted + act_sel_pkg::CNT_W'(1);
          end
          step_next = step + act_sel_pkg::STEP_W'(1);
          if (step == act_sel_pkg::STEP_W'(act_sel_pkg::MAX_ACTIVITIES - 1)) begin
            state_next  = act_sel_pkg::ST_LOAD;
            step_next   = '0;
            loaded_next = '0;
          end
        end
      end

      default: state_next = act_sel_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= act_sel_pkg::ST_LOAD;
      loaded     <= '0;
      cnt        <= '0;
      emitted    <= '0;
      step       <= '0;
      have_taken <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      loaded     <= loaded_next;
      cnt        <= cnt_next;
      emitted    <= emitted_next;
      step       <= step_next;
      have_taken <= have_taken_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    taken_start  <= taken_start_next;
    chosen_id    <= out_id_next;
    chosen_count <= out_cnt_next;
    final_result <= out_final_next;
  end

endmodule

// ===== tb/activity_selection_sorted_unit_test.sv =====
`timescale 1ns / 100ps
// Testbench for activity_selection_sorted_unit: streams activity sets in, predicts the
// greedy selection of each set, and checks every chosen id, count and final flag.
// Depends on act_sel_pkg and the unit's RTL.
module activity_selection_sorted_unit_test;
  localparam int MAX_ACTIVITIES = act_sel_pkg::MAX_ACTIVITIES;
  localparam int ID_W           = act_sel_pkg::ID_W;
  localparam int TIME_W         = act_sel_pkg::TIME_W;
  localparam int CNT_W          = act_sel_pkg::CNT_W;

  localparam int TARGET_ITEMS  = 480;
  localparam int MAX_SET       = MAX_ACTIVITIES + 6;
  localparam int HOLD_CYCLES   = 600;
  localparam int DRAIN_CYCLES  = 3 * MAX_ACTIVITIES + 16;
  localparam int REPORT_LIMIT  = 40;
  localparam int NUM_DIRECTED  = 20;
  localparam int PAUSE_AT_SET  = 12;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] count;
    logic             final_flag;
  } choice_t;
  typedef choice_t choice_q_t[$];

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] stop;
    logic              is_last;
    logic              typed;
    logic [ID_W-1:0]   want_id;
  } directed_row_t;

  typedef enum int {
    STYLE_CHAIN,
    STYLE_RANDOM,
    STYLE_TIES,
    STYLE_EXTREME
  } set_style_t;

  typedef enum int {
    RX_ALWAYS,
    RX_THREE_OF_FOUR,
    RX_COIN,
    RX_ONE_OF_FIVE
  } stall_mode_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [ID_W-1:0]   activity_id;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] end_time;
  logic              last;
  logic              out_valid;
  logic              out_ready;
  logic [ID_W-1:0]   chosen_id;
  logic [CNT_W-1:0]  chosen_count;
  logic              final_result;

  activity_selection_sorted_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .activity_id  (activity_id),
    .start_time   (start_time),
    .end_time     (end_time),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .chosen_id    (chosen_id),
    .chosen_count (chosen_count),
    .final_result (final_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directed sets: extremes, overlap, equal starts, end equal to start, end before start.
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{15'h0000, 15'h0000, 15'h0000, 1'b1, 1'b1, 15'h0000},
    '{15'h7fff, 15'h7fff, 15'h7fff, 1'b1, 1'b1, 15'h7fff},
    '{15'h1234, 15'd100,  15'd200,  1'b0, 1'b0, 15'h0000},
    '{15'h0042, 15'd50,   15'd150,  1'b1, 1'b1, 15'h1234},
    '{15'h0001, 15'd5,    15'd5,    1'b0, 1'b0, 15'h0000},
    '{15'h0002, 15'd5,    15'd3,    1'b0, 1'b0, 15'h0000},
    '{15'h0003, 15'd5,    15'd5,    1'b1, 1'b0, 15'h0000},
    '{15'h0010, 15'd1000, 15'd2000, 1'b0, 1'b0, 15'h0000},
    '{15'h0011, 15'd0,    15'd1000, 1'b0, 1'b0, 15'h0000},
    '{15'h0012, 15'd2000, 15'h7fff, 1'b1, 1'b0, 15'h0000},
    '{15'h5555, 15'h2aaa, 15'h5555, 1'b0, 1'b0, 15'h0000},
    '{15'h2aaa, 15'h5555, 15'h7fff, 1'b0, 1'b0, 15'h0000},
    '{15'h7fff, 15'h0000, 15'h2aaa, 1'b1, 1'b0, 15'h0000},
    '{15'h0020, 15'd300,  15'd10,   1'b0, 1'b0, 15'h0000},
    '{15'h0021, 15'd200,  15'd250,  1'b0, 1'b0, 15'h0000},
    '{15'h0022, 15'd20,   15'd5,    1'b1, 1'b0, 15'h0000},
    '{15'h0030, 15'd7,    15'd7,    1'b0, 1'b0, 15'h0000},
    '{15'h0031, 15'd7,    15'd7,    1'b0, 1'b0, 15'h0000},
    '{15'h0032, 15'd7,    15'd7,    1'b0, 1'b0, 15'h0000},
    '{15'h0033, 15'd7,    15'd7,    1'b1, 1'b0, 15'h0000}
  };

  logic [ID_W-1:0]   held_id    [MAX_ACTIVITIES];
  logic [TIME_W-1:0] held_start [MAX_ACTIVITIES];
  logic [TIME_W-1:0] held_stop  [MAX_ACTIVITIES];
  int                held_count = 0;

  choice_q_t pending_choices;
  choice_t   front_choice;
  int        mismatches = 0;
  int        loaded_items;
  int        burst_left = 0;
  bit        hold_request = 1'b0;
  bit        hold_served = 1'b0;

  // Stores one activity; on the closing one, runs the greedy selection over the set.
  function automatic choice_q_t load_and_select(input logic [ID_W-1:0] id,
                                                input logic [TIME_W-1:0] start,
                                                input logic [TIME_W-1:0] stop,
                                                input logic is_last);
    int        order  [MAX_ACTIVITIES];
    bit        picked [MAX_ACTIVITIES];
    choice_q_t picks;
    choice_t   pick;
    int        n, i, k, taken, count, emitted;
    if (held_count < MAX_ACTIVITIES) begin
      held_id[held_count]    = id;
      held_start[held_count] = start;
      held_stop[held_count]  = stop;
      held_count++;
    end
    if (!is_last || held_count == 0) return picks;
    n = held_count;
    for (i = 0; i < n; i++) begin
      k = i;
      while (k > 0 && held_start[order[k-1]] < held_start[i]) begin
        order[k] = order[k-1];
        k--;
      end
      order[k] = i;
    end
    for (i = 0; i < MAX_ACTIVITIES; i++) picked[i] = 1'b0;
    picked[order[0]] = 1'b1;
    taken = order[0];
    count = 1;
    for (i = 1; i < n; i++) begin
      if (held_stop[order[i]] <= held_start[taken]) begin
        picked[order[i]] = 1'b1;
        taken = order[i];
        count++;
      end
    end
    emitted = 0;
    for (i = n - 1; i >= 0; i--) begin
      if (picked[order[i]]) begin
        emitted++;
        pick.id         = held_id[order[i]];
        pick.count      = CNT_W'(count);
        pick.final_flag = (emitted == count);
        picks.push_back(pick);
      end
    end
    held_count = 0;
    return picks;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < REPORT_LIMIT)
      $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Offers one activity in bursts with random gaps, then records its prediction.
  task automatic send_activity(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] start,
                               input logic [TIME_W-1:0] stop, input logic is_last,
                               input bit typed, input logic [ID_W-1:0] want_id);
    choice_q_t picks;
    choice_t   typed_pick;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid    <= 1'b1;
    activity_id <= id;
    start_time  <= start;
    end_time    <= stop;
    last        <= is_last;
    do @(posedge clk); while (!in_ready);
    if (held_count < MAX_ACTIVITIES) loaded_items++;
    picks = load_and_select(id, start, stop, is_last);
    if (typed && is_last) begin
      typed_pick.id         = want_id;
      typed_pick.count      = CNT_W'(1);
      typed_pick.final_flag = 1'b1;
      pending_choices.push_back(typed_pick);
    end else begin
      foreach (picks[i]) pending_choices.push_back(picks[i]);
    end
  endtask

  function automatic logic [14:0] extreme_value();
    case ($urandom_range(0, 6))
      0: return 15'h0000;
      1: return 15'h0001;
      2: return 15'h3fff;
      3: return 15'h4000;
      4: return 15'h7ffe;
      5: return 15'h7fff;
      default: return 15'($urandom_range(0, 32767));
    endcase
  endfunction

  task automatic send_random_set(input int size, input set_style_t style);
    logic [ID_W-1:0]   ids    [MAX_SET];
    logic [TIME_W-1:0] starts [MAX_SET];
    logic [TIME_W-1:0] stops  [MAX_SET];
    int                slot   [MAX_SET];
    int                i, j, tmp, step;
    step = 32000 / size;
    for (i = 0; i < size; i++) begin
      slot[i] = i;
      ids[i]  = 15'($urandom_range(0, 32767));
      case (style)
        STYLE_CHAIN: begin
          starts[i] = 15'(i * step + $urandom_range(0, step / 3));
          stops[i]  = 15'(starts[i] + $urandom_range(0, step / 2));
        end
        STYLE_TIES: begin
          starts[i] = 15'($urandom_range(0, 15));
          stops[i]  = 15'($urandom_range(0, 15));
        end
        STYLE_EXTREME: begin
          ids[i]    = extreme_value();
          starts[i] = extreme_value();
          stops[i]  = extreme_value();
        end
        default: begin
          starts[i] = 15'($urandom_range(0, 32767));
          stops[i]  = 15'($urandom_range(0, 32767));
        end
      endcase
    end
    for (i = size - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = slot[i];
      slot[i] = slot[j];
      slot[j] = tmp;
    end
    for (i = 0; i < size; i++)
      send_activity(ids[slot[i]], starts[slot[i]], stops[slot[i]], i == size - 1, 1'b0, '0);
  endtask

  initial begin : stimulus
    int         set_index, r, size;
    set_style_t style;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    activity_id <= '0;
    start_time  <= '0;
    end_time    <= '0;
    last        <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_activity(directed_rows[i].id, directed_rows[i].start, directed_rows[i].stop,
                    directed_rows[i].is_last, directed_rows[i].typed, directed_rows[i].want_id);

    loaded_items = 0;
    set_index = 0;
    while (loaded_items < TARGET_ITEMS) begin
      if (set_index == 0) begin
        // long receiver hold-off while a full set and the next one are offered
        hold_request = 1'b1;
        send_random_set(MAX_ACTIVITIES, STYLE_CHAIN);
      end else if (set_index == 1) begin
        send_random_set(MAX_ACTIVITIES + 2, STYLE_RANDOM);
      end else begin
        if (set_index == PAUSE_AT_SET) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (pending_choices.size() != 0);
        end
        r = $urandom_range(0, 99);
        if (r < 60)      size = $urandom_range(1, 8);
        else if (r < 88) size = $urandom_range(9, 24);
        else if (r < 96) size = $urandom_range(48, MAX_ACTIVITIES);
        else             size = $urandom_range(MAX_ACTIVITIES + 1, MAX_SET);
        r = $urandom_range(0, 99);
        if (r < 45)      style = STYLE_CHAIN;
        else if (r < 70) style = STYLE_RANDOM;
        else if (r < 85) style = STYLE_TIES;
        else             style = STYLE_EXTREME;
        send_random_set(size, style);
      end
      set_index++;
    end

    in_valid <= 1'b0;
    while (pending_choices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_choices.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : receiver
    stall_mode_t mode;
    int          mode_left, tick;
    out_ready <= 1'b0;
    mode = RX_ALWAYS;
    mode_left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 80);
        end
        mode_left--;
        case (mode)
          RX_ALWAYS:        out_ready <= 1'b1;
          RX_THREE_OF_FOUR: out_ready <= (tick % 4 != 3);
          RX_COIN:          out_ready <= 1'($urandom_range(0, 1));
          default:          out_ready <= (tick % 5 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_choices.size() == 0) begin
        report_mismatch("unexpected transfer, chosen_id", chosen_id, 0);
      end else begin
        front_choice = pending_choices.pop_front();
        if (chosen_id !== front_choice.id)
          report_mismatch("chosen_id", chosen_id, front_choice.id);
        if (chosen_count !== front_choice.count)
          report_mismatch("chosen_count", chosen_count, front_choice.count);
        if (final_result !== front_choice.final_flag)
          report_mismatch("final_result", final_result, front_choice.final_flag);
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
